FILE: src/integer_merge_sorter_unit_defines.svh
// Assertion macros shared by the sorter's checker.
// Depends on nothing; include by bare file name.
`ifndef INTEGER_MERGE_SORTER_UNIT_DEFINES_SVH
`define INTEGER_MERGE_SORTER_UNIT_DEFINES_SVH

// Clocked property, disabled while reset is high.
`define IMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen.
`define IMS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `IMS_ASSERT(label, clk, rst, !(expr), msg)

`endif

FILE: src/ims_pkg.sv
// Types shared by the insertion-cell sorter: payload structs and cell control.
// No dependencies.
package ims_pkg;

   typedef logic signed [31:0] value_type;

   // Input transfer payload
   typedef struct packed {
      value_type value;
      logic      last_item;
   } req_payload_type;

   // Result transfer payload
   typedef struct packed {
      value_type sorted_value;
      logic      last_result;
      logic      overflow;
   } rsp_payload_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic      insert;
      logic      shift_out;
      value_type value;
   } cell_ctrl_type;

endpackage

FILE: src/integer_merge_sorter_unit.sv
// Sorter for sets of signed 32-bit values. While a set is collected, one value is taken per
// cycle and inserted at once into a chain of CAPACITY compare-and-shift cells that keeps the
// set in ascending order. The transfer that carries last_item is inserted too and starts the
// drain: the chain then shifts toward cell 0 and gives one result per cycle while rsp_ready
// is high, the greatest value flagged last_result. No input is taken during the drain; the next
// set can start in the cycle after its final result transfers. Values that arrive with all
// cells full are dropped and every result of that set shows overflow. Depends on ims_pkg and
// ims_cell.
module integer_merge_sorter_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ims_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ims_pkg::rsp_payload_type rsp_data
);

   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_DRAIN   = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      dropped_ff, dropped_in;

   logic               pos_w   [CAPACITY];
   logic               valid_w [CAPACITY];
   ims_pkg::value_type value_w [CAPACITY];

   ims_pkg::cell_ctrl_type ctrl;
   logic req_xfer, rsp_xfer, final_xfer, full;

   assign full       = valid_w[CAPACITY-1];
   assign req_ready  = (state_ff == ST_COLLECT);
   assign req_xfer   = req_valid && req_ready;
   assign rsp_valid  = (state_ff == ST_DRAIN) && valid_w[0];
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign final_xfer = rsp_xfer && rsp_data.last_result;

   // Results come straight from the head cell
   assign rsp_data.sorted_value = value_w[0];
   assign rsp_data.last_result  = !valid_w[1];
   assign rsp_data.overflow     = dropped_ff;

   // Broadcast control to the chain
   assign ctrl.insert    = req_xfer && !full;
   assign ctrl.shift_out = rsp_xfer;
   assign ctrl.value     = req_data.value;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               l_pos, l_valid, r_valid;
      ims_pkg::value_type l_value, r_value;
      if (i == 0) begin : g_head
         assign l_pos   = 1'b0;
         assign l_valid = 1'b1;
         assign l_value = req_data.value;
      end else begin : g_body
         assign l_pos   = pos_w[i-1];
         assign l_valid = valid_w[i-1];
         assign l_value = value_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_value = '0;
      end else begin : g_next
         assign r_valid = valid_w[i+1];
         assign r_value = value_w[i+1];
      end
      ims_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_pos    (l_pos),
         .left_valid  (l_valid),
         .left_value  (l_value),
         .right_valid (r_valid),
         .right_value (r_value),
         .pos         (pos_w[i]),
         .valid       (valid_w[i]),
         .value       (value_w[i])
      );
   end

   // Collect / drain sequencing and overflow tracking
   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      if (req_xfer && full) begin
         dropped_in = 1'b1;
      end
      case (state_ff)
         ST_COLLECT: begin
            if (req_xfer && req_data.last_item) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (final_xfer) begin
               state_in   = ST_COLLECT;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_COLLECT;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

FILE: src/ims_cell.sv
// One cell of the sorted insertion chain: holds one value and its valid bit.
// Depends on ims_pkg.
module ims_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ims_pkg::cell_ctrl_type ctrl,
   input  logic                  left_pos,
   input  logic                  left_valid,
   input  ims_pkg::value_type    left_value,
   input  logic                  right_valid,
   input  ims_pkg::value_type    right_value,
   output logic                  pos,
   output logic                  valid,
   output ims_pkg::value_type    value
);

   logic               valid_ff, valid_in;
   ims_pkg::value_type value_ff, value_in;

   // New value belongs here or to the left: slot is empty or holds a greater value
   assign pos   = !valid_ff || (ctrl.value < value_ff);
   assign valid = valid_ff;
   assign value = value_ff;

   // Insert: the first position takes the new value, later ones shift right.
   // Drain: every cell takes its right neighbor.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.shift_out) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.insert && pos) begin
         value_in = left_pos ? left_value : ctrl.value;
         valid_in = valid_ff || left_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: src/ims_checker.sv
// Port-level checker for the sorter, bound to the top level.
// Depends on ims_pkg and the assertion macro header.
`include "integer_merge_sorter_unit_defines.svh"

module ims_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input ims_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ims_pkg::rsp_payload_type rsp_data
);

   logic req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // No input taken while a set is being emitted
   `IMS_ASSERT_NEVER(a_no_req_during_drain, clock, reset, rsp_valid && req_ready, "input taken during drain")

   // Closing transfer starts the result stream
   `IMS_ASSERT(a_drain_starts, clock, reset, (req_xfer && req_data.last_item) |=> rsp_valid, "no result after closing transfer")

   // Results ascend and overflow holds within a set
   `IMS_ASSERT(a_ascending, clock, reset, (rsp_xfer && !rsp_data.last_result) |=> (rsp_valid && ($signed(rsp_data.sorted_value) >= $signed($past(rsp_data.sorted_value))) && (rsp_data.overflow == $past(rsp_data.overflow))), "results out of order or overflow changed")

   // Final result reopens the input
   `IMS_ASSERT(a_reopen, clock, reset, (rsp_xfer && rsp_data.last_result) |=> (req_ready && !rsp_valid), "input not reopened after final result")

endmodule

bind integer_merge_sorter_unit ims_checker u_ims_checker (.*);
